// ===== rtl/core/tsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants of the topological sort core.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int CFG_W     = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0] NUM_NODES_RESET = CFG_W'(MAX_NODES);

    // Register index of the node count register.
    localparam logic REG_NUM_NODES = 1'b0;

    typedef struct packed {
        logic              edge_valid;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              found;
        logic              run_end;
    } t_out_word;

    typedef enum logic {
        ST_LOAD,
        ST_SORT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_edge;
        logic emit;
        logic clear;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
        logic pick_found;
        logic pick_final;
    } t_dp_stat;

    // Node count in effect: zero acts as one, anything above the maximum
    // acts as the maximum.
    function automatic logic [CNT_W-1:0] nodes_in_use(input logic [CFG_W-1:0] raw);
        logic [CNT_W-1:0] n;
        begin
            n = CNT_W'(raw);
            if (raw == '0) begin
                n = CNT_W'(1);
            end else if (CNT_W'(raw) > CNT_W'(MAX_NODES)) begin
                n = CNT_W'(MAX_NODES);
            end
            return n;
        end
    endfunction

endpackage

// ===== rtl/core/topological_sort_adjacency_matrix_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topological_sort_adjacency_matrix_core
// Kahn topological sort over a 16-node graph held as incoming-edge masks.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Word
//  --------  ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready   edge_valid, src, dst, last
//  out       source     o_out_valid / i_out_ready node, found, run_end
//  cfg       APB        psel, penable, pready     num_nodes at byte address 0
//
// Each input word is taken as soon as it is valid while the core is loading.
// The word marked last starts a run: the state register moves to sorting and
// from there the first result is registered; then one result follows per
// cycle while the consumer takes them. A run gives at most as many results as
// the node count in effect, since a cycle terminator only stands in for nodes
// that can never be emitted. The selection of the next ready node is
// combinational: mask tests and a priority encoder over the sixteen entries of
// the store. No input word is accepted during a run. Stalls on the output
// simply hold the result register and the search. Synchronous reset clears the
// store, the flags and the run state, and sets the node count to sixteen.
//
// ----------------------------------------------------------------------------
module topological_sort_adjacency_matrix_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tsa_pkg::t_in_word               i_in_word,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tsa_pkg::t_out_word              o_out_word,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsa_pkg::PADDR_W-1:0]     paddr,
    input  logic [tsa_pkg::PDATA_W-1:0]     pwdata,
    output logic [tsa_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    // Node count register. Only the low five bits of a write are kept; the
    // clamp to the range one to sixteen is applied where the count is used.
    logic [tsa_pkg::CFG_W-1:0] r_num_nodes;
    logic [tsa_pkg::CNT_W-1:0] num_nodes_eff;
    logic                      reg_sel;

    tsa_pkg::t_dp_cmd  cmd;
    tsa_pkg::t_dp_stat stat;

    // Address bit two selects the register; addresses with that bit set
    // read zero and ignore writes.
    assign reg_sel = paddr[2] == tsa_pkg::REG_NUM_NODES;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= tsa_pkg::NUM_NODES_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_num_nodes <= pwdata[tsa_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = tsa_pkg::PDATA_W'(r_num_nodes);
        end
    end

    assign num_nodes_eff = tsa_pkg::nodes_in_use(r_num_nodes);

    // The controller decides when an edge is stored, when a result is
    // produced and when the run is closed; the datapath holds the graph.
    tsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_word.last),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    tsa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_num_nodes (num_nodes_eff),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/core/tsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_ctrl
// Controller: sequences edge loading, the sort run and the store clear.
// ----------------------------------------------------------------------------
module tsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic              i_out_ready,
    input  tsa_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output tsa_pkg::t_dp_cmd  o_cmd
);

    tsa_pkg::t_state r_state;
    tsa_pkg::t_state n_state;
    logic            out_free;

    assign out_free = !i_stat.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsa_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tsa_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_edge = 1'b1;
                    if (i_in_last) begin
                        n_state = tsa_pkg::ST_SORT;
                    end
                end
            end
            tsa_pkg::ST_SORT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    // A terminator or the last node closes the run.
                    if (!i_stat.pick_found || i_stat.pick_final) begin
                        o_cmd.clear = 1'b1;
                        n_state     = tsa_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = tsa_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/tsa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_datapath
// Adjacency store, removed flags, node selection and the result register.
// ----------------------------------------------------------------------------
module tsa_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tsa_pkg::t_dp_cmd                i_cmd,
    input  tsa_pkg::t_in_word               i_in_word,
    input  logic [tsa_pkg::CNT_W-1:0]       i_num_nodes,
    input  logic                            i_out_ready,
    output tsa_pkg::t_dp_stat               o_stat,
    output logic                            o_out_valid,
    output tsa_pkg::t_out_word              o_out_word
);

    logic [tsa_pkg::MAX_NODES-1:0] r_mask [tsa_pkg::MAX_NODES];
    logic [tsa_pkg::MAX_NODES-1:0] r_removed;
    logic [tsa_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_out_valid;
    tsa_pkg::t_out_word            r_out_word;

    logic [tsa_pkg::MAX_NODES-1:0] active;
    logic [tsa_pkg::MAX_NODES-1:0] cand;
    logic [tsa_pkg::NODE_W-1:0]    pick_idx;
    logic                          pick_found;
    logic                          pick_final;
    logic                          edge_ok;
    tsa_pkg::t_out_word            n_out_word;

    // Node i is ready when it is in use, not yet removed, and every source
    // of an incoming edge is either out of use or already removed.
    always_comb begin
        for (int i = 0; i < tsa_pkg::MAX_NODES; i++) begin
            active[i] = tsa_pkg::CNT_W'(i) < i_num_nodes;
        end
        for (int i = 0; i < tsa_pkg::MAX_NODES; i++) begin
            cand[i] = active[i] && !r_removed[i]
                      && ((r_mask[i] & active & ~r_removed) == '0);
        end
        pick_idx = '0;
        for (int i = tsa_pkg::MAX_NODES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pick_idx = tsa_pkg::NODE_W'(i);
            end
        end
    end

    assign pick_found = |cand;
    assign pick_final = (r_cnt + tsa_pkg::CNT_W'(1)) == i_num_nodes;

    assign edge_ok = i_in_word.edge_valid
                     && (tsa_pkg::CNT_W'(i_in_word.src) < i_num_nodes)
                     && (tsa_pkg::CNT_W'(i_in_word.dst) < i_num_nodes);

    always_comb begin
        n_out_word.node    = pick_found ? pick_idx : '0;
        n_out_word.found   = pick_found;
        n_out_word.run_end = pick_found ? pick_final : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsa_pkg::MAX_NODES; i++) begin
                r_mask[i] <= '0;
            end
            r_removed   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                for (int i = 0; i < tsa_pkg::MAX_NODES; i++) begin
                    r_mask[i] <= '0;
                end
                r_removed <= '0;
                r_cnt     <= '0;
            end else begin
                if (i_cmd.store_edge && edge_ok) begin
                    r_mask[i_in_word.dst][i_in_word.src] <= 1'b1;
                end
                if (i_cmd.emit && pick_found) begin
                    r_removed[pick_idx] <= 1'b1;
                    r_cnt               <= r_cnt + tsa_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_stat.out_valid  = r_out_valid;
    assign o_stat.pick_found = pick_found;
    assign o_stat.pick_final = pick_final;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    // The emitted count always tracks the removed flags.
    a_cnt_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_removed) == int'(r_cnt))
        else $error("emitted count differs from removed flags");

    // A terminator always closes the run.
    a_term_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.found) |-> r_out_word.run_end)
        else $error("terminator without run end");

    // Closing a run leaves the flags and count empty.
    a_clear_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_removed == '0) && (r_cnt == '0))
        else $error("run state not cleared");

    // A node is emitted only while the result register can take it.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before taken");

endmodule
